FILE: rtl/core/lpfp_pkg.sv
// shared codes and result type for the length-prefixed frame parser
package lpfp_pkg;

	localparam logic [2:0] PH_LEN_HI  = 3'd0;
	localparam logic [2:0] PH_LEN_LO  = 3'd1;
	localparam logic [2:0] PH_HLEN_HI = 3'd2;
	localparam logic [2:0] PH_HLEN_LO = 3'd3;
	localparam logic [2:0] PH_HEADER  = 3'd4;
	localparam logic [2:0] PH_BODY    = 3'd5;

	localparam logic [1:0] KIND_LEN    = 2'd0;
	localparam logic [1:0] KIND_HEADER = 2'd1;
	localparam logic [1:0] KIND_BODY   = 2'd2;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] byte_kind;
		logic       header_end;
		logic       frame_end;
		logic       length_error;
	} res_t;

endpackage

FILE: rtl/core/lpfp_in_reg.sv
// input register stage of the frame parser
module lpfp_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] in_byte,
	input  logic       advance,
	output logic       in_stall,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);
	logic accept;

	// the stage frees itself in the same cycle it hands its byte on
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_byte;
		end
	end
endmodule

FILE: rtl/core/lpfp_parse.sv
// frame state tracking and per-byte tagging
module lpfp_parse (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  logic [7:0]    byte_s1,
	output lpfp_pkg::res_t res
);
	import lpfp_pkg::*;

	logic [2:0]  phase_q, phase_d;
	logic [15:0] msg_len_q, msg_len_d;
	logic [15:0] hdr_rem_q, hdr_rem_d;
	logic [15:0] body_rem_q, body_rem_d;
	logic [15:0] hdr_len;
	logic [16:0] need;
	logic        too_long;
	logic [15:0] body_len;
	logic [15:0] hdr_dec;
	logic [15:0] body_dec;

	assign hdr_len  = {hdr_rem_q[15:8], byte_s1};
	assign need     = {1'b0, hdr_len} + 17'd2;
	assign too_long = need > {1'b0, msg_len_q};
	assign body_len = too_long ? 16'd0 : (msg_len_q - need[15:0]);
	assign hdr_dec  = hdr_rem_q - 16'd1;
	assign body_dec = body_rem_q - 16'd1;

	always_comb begin
		phase_d          = phase_q;
		msg_len_d        = msg_len_q;
		hdr_rem_d        = hdr_rem_q;
		body_rem_d       = body_rem_q;
		res.out_byte     = byte_s1;
		res.byte_kind    = KIND_LEN;
		res.header_end   = 1'b0;
		res.frame_end    = 1'b0;
		res.length_error = 1'b0;
		unique case (phase_q)
			PH_LEN_LO: begin
				msg_len_d = {msg_len_q[15:8], byte_s1};
				phase_d   = PH_HLEN_HI;
			end
			PH_HLEN_HI: begin
				hdr_rem_d = {byte_s1, 8'h00};
				phase_d   = PH_HLEN_LO;
			end
			PH_HLEN_LO: begin
				hdr_rem_d        = hdr_len;
				body_rem_d       = body_len;
				res.length_error = too_long;
				if (hdr_len != 16'd0) begin
					phase_d = PH_HEADER;
				end else if (body_len != 16'd0) begin
					phase_d = PH_BODY;
				end else begin
					res.frame_end = 1'b1;
					phase_d       = PH_LEN_HI;
				end
			end
			PH_HEADER: begin
				res.byte_kind = KIND_HEADER;
				hdr_rem_d     = hdr_dec;
				if (hdr_dec == 16'd0) begin
					res.header_end = 1'b1;
					if (body_rem_q != 16'd0) begin
						phase_d = PH_BODY;
					end else begin
						res.frame_end = 1'b1;
						phase_d       = PH_LEN_HI;
					end
				end
			end
			PH_BODY: begin
				res.byte_kind = KIND_BODY;
				body_rem_d    = body_dec;
				if (body_dec == 16'd0) begin
					res.frame_end = 1'b1;
					phase_d       = PH_LEN_HI;
				end
			end
			default: begin
				// first length byte, also taken for unused phase codes
				msg_len_d = {byte_s1, 8'h00};
				phase_d   = PH_LEN_LO;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_LEN_HI;
			msg_len_q  <= 16'd0;
			hdr_rem_q  <= 16'd0;
			body_rem_q <= 16'd0;
		end else if (advance) begin
			phase_q    <= phase_d;
			msg_len_q  <= msg_len_d;
			hdr_rem_q  <= hdr_rem_d;
			body_rem_q <= body_rem_d;
		end
	end
endmodule

FILE: rtl/core/lpfp_out_reg.sv
// result register of the frame parser
module lpfp_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_s1,
	input  lpfp_pkg::res_t res,
	input  logic           out_stall,
	output logic           advance,
	output logic           out_valid,
	output lpfp_pkg::res_t res_q
);
	import lpfp_pkg::*;

	// take a new result when the register is empty or its transaction completes
	assign advance = valid_s1 && (!out_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end
endmodule

FILE: rtl/core/length_prefixed_frame_parser_unit.sv
// Length-prefixed frame parser: takes one byte per cycle unless stalled and
// tags each byte as length field, header or body, marking the last header
// byte, the end of each frame and a header length that does not fit the
// message length. A frame is a 16-bit big-endian message length, a 16-bit
// big-endian header length, the header bytes and then the rest of the message
// as body. Throughput is one byte per clock while out_stall is low; each byte
// passes through an input register and a result register, and the per-byte
// work is a single counter update and compare between them.
module length_prefixed_frame_parser_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [1:0] byte_kind,
	output logic       header_end,
	output logic       frame_end,
	output logic       length_error
);
	import lpfp_pkg::*;

	logic       advance;
	logic       valid_s1;
	logic [7:0] byte_s1;
	res_t       res;
	res_t       res_q;

	lpfp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_byte  (in_byte),
		.advance  (advance),
		.in_stall (in_stall),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	lpfp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.res     (res)
	);

	lpfp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res       (res),
		.out_stall (out_stall),
		.advance   (advance),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign out_byte     = res_q.out_byte;
	assign byte_kind    = res_q.byte_kind;
	assign header_end   = res_q.header_end;
	assign frame_end    = res_q.frame_end;
	assign length_error = res_q.length_error;

`ifndef SYNTHESIS
	a_hdr_end_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && header_end |-> byte_kind == KIND_HEADER)
		else $error("header end on a byte that is not a header byte");

	a_len_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && length_error |-> byte_kind == KIND_LEN)
		else $error("length error on a byte that is not a length byte");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled while the pipeline can move");

	a_advance_load: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("result register empty after a load");
`endif
endmodule
